@@ hdl/vcot_pkg.sv @@
// Shared types, codes and default sizes for the VC credit occupancy tracker.
package vcot_pkg;

    localparam int DEF_NUM_PORTS     = 8;
    localparam int DEF_NUM_VCS       = 4;
    localparam int DEF_MAX_CREDITS   = 255;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int OP_W       = 2;
    localparam int PORT_W     = 3;
    localparam int CHAN_W     = 2;
    localparam int CREDIT_W   = 8;
    localparam int ERR_W      = 2;
    localparam int IN_FIELD_W = OP_W + PORT_W + CHAN_W + CREDIT_W;
    localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_INC   = 2'd1,
        OP_DEC   = 2'd2,
        OP_QUERY = 2'd3
    } vcot_op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK          = 2'd0,
        ERR_INC_AT_MAX  = 2'd1,
        ERR_DEC_AT_ZERO = 2'd2,
        ERR_MAX_ZERO    = 2'd3
    } vcot_err_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_UPDATE = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_FINISH = 2'd3
    } vcot_state_t;

    typedef struct packed {
        logic [CREDIT_W-1:0] maximum;
        logic [CREDIT_W-1:0] count;
    } vcot_entry_t;

endpackage

@@ hdl/vcot_table.sv @@
// Credit table: one synchronous RAM of count/maximum pairs with per-entry valid bits.
module vcot_table
    import vcot_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_PORTS * DEF_NUM_VCS,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output vcot_entry_t       rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  vcot_entry_t       wr_data
);

    vcot_entry_t        mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    vcot_entry_t        rdata_reg;
    logic               rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset value
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

@@ hdl/vcot_divider.sv @@
// Bit-serial restoring divider: (dividend << FRACTION_BITS) / divisor, one quotient bit a cycle.
module vcot_divider
    import vcot_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CREDIT_W-1:0]      dividend,
    input  logic [CREDIT_W-1:0]      divisor,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quotient
);

    localparam int STEPS = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [CREDIT_W:0]      rem_reg,   rem_next;
    logic [CREDIT_W-1:0]    div_reg,   div_next;
    logic [FRACTION_BITS:0] quot_reg,  quot_next;

    logic                   ge;
    logic [CREDIT_W:0]      rem_sub;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, div_reg};
        rem_sub   = ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, dividend};
            div_next  = divisor;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the shift cannot overflow
            quot_next = {quot_reg[FRACTION_BITS-1:0], ge};
            rem_next  = {rem_sub[CREDIT_W-1:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ hdl/vc_credit_occupancy_tracker.sv @@
// Top level of the VC credit occupancy tracker: handshake, sequencer and result register.
//
// Keeps a credit count and a credit maximum for each virtual channel of each router
// port in a small synchronous RAM (entry = port * NUM_VCS + vc, all zero after reset).
// Each input word carries an operation (init, increment, decrement, query), a port, a
// channel and a credit value; each word yields exactly one result word holding the
// channel's occupancy (max - count) / max as an unsigned Q1.FRACTION_BITS fraction,
// truncated, plus an error code: increment at max and decrement at zero hold the count,
// a zero maximum or an out-of-range port/channel reports fraction 0 and code 3, the
// latter leaving the table untouched. Init saturates the credit value to MAX_CREDITS.
// One word is in flight at a time: after acceptance a word passes the RAM read, the
// update and write-back state, the bit-serial divider, which produces one quotient bit
// a cycle, and the finish state, which waits for a free output register and loads it.
// Words that skip the division go from the update state straight to the finish state.
// The output register frees the input side, so the next word is accepted while the
// previous result still waits to be taken.
module vc_credit_occupancy_tracker
    import vcot_pkg::*;
#(
    parameter int NUM_PORTS     = DEF_NUM_PORTS,
    parameter int NUM_VCS       = DEF_NUM_VCS,
    parameter int MAX_CREDITS   = DEF_MAX_CREDITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int OUT_FIELD_W  = FRACTION_BITS + 1 + ERR_W,
    localparam int OUT_TDATA_W  = ((OUT_FIELD_W + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [1:0] operation, [4:2] port_number, [6:5] channel_number, [14:7] credit_value
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [FRACTION_BITS:0] occupancy_fraction, then error_code (2 bits)
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int DEPTH = NUM_PORTS * NUM_VCS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Unpack the input word
    vcot_op_t               in_op;
    logic [PORT_W-1:0]      in_port;
    logic [CHAN_W-1:0]      in_chan;
    logic [CREDIT_W-1:0]    in_credit;
    logic                   in_range;
    logic [IDX_W-1:0]       in_idx;
    logic                   in_accept;

    assign in_op     = vcot_op_t'(s_axis_tdata[OP_W-1:0]);
    assign in_port   = s_axis_tdata[OP_W +: PORT_W];
    assign in_chan   = s_axis_tdata[OP_W + PORT_W +: CHAN_W];
    assign in_credit = s_axis_tdata[OP_W + PORT_W + CHAN_W +: CREDIT_W];
    assign in_range  = (32'(in_port) < NUM_PORTS) && (32'(in_chan) < NUM_VCS);
    // hold the address at zero for an out-of-range port or channel so the RAM is never overrun
    assign in_idx    = in_range ? IDX_W'(32'(in_port) * NUM_VCS + 32'(in_chan)) : '0;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Sequencer and word registers
    vcot_state_t            state_reg,     state_next;
    vcot_op_t               op_reg,        op_next;
    logic [IDX_W-1:0]       idx_reg,       idx_next;
    logic [CREDIT_W-1:0]    credit_reg,    credit_next;
    logic                   range_reg,     range_next;
    logic [FRACTION_BITS:0] frac_reg,      frac_next;
    vcot_err_t              err_reg,       err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FRACTION_BITS:0] out_frac_reg,  out_frac_next;
    vcot_err_t              out_err_reg,   out_err_next;

    // Table and divider connections
    vcot_entry_t            rd_entry;
    vcot_entry_t            upd_entry;
    vcot_err_t              upd_err;
    logic [CREDIT_W-1:0]    init_credit;
    logic                   tbl_wr_en;
    logic                   div_start;
    logic                   div_done;
    logic [FRACTION_BITS:0] div_quot;
    logic                   out_free;

    vcot_table #(
        .DEPTH   (DEPTH),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_idx),
        .rd_data (rd_entry),
        .wr_en   (tbl_wr_en),
        .wr_addr (idx_reg),
        .wr_data (upd_entry)
    );

    vcot_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (upd_entry.maximum - upd_entry.count),
        .divisor  (upd_entry.maximum),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Read-modify step on the entry returned by the RAM
    assign init_credit = (32'(credit_reg) > MAX_CREDITS) ? CREDIT_W'(MAX_CREDITS) : credit_reg;

    always_comb
    begin
        upd_entry = rd_entry;
        upd_err   = ERR_OK;
        unique case (op_reg)
            OP_INIT:
            begin
                upd_entry.maximum = init_credit;
                upd_entry.count   = init_credit;
            end
            OP_INC:
            begin
                if (rd_entry.count < rd_entry.maximum)
                begin
                    upd_entry.count = rd_entry.count + 1'b1;
                end
                else
                begin
                    upd_err = ERR_INC_AT_MAX;
                end
            end
            OP_DEC:
            begin
                if (rd_entry.count != '0)
                begin
                    upd_entry.count = rd_entry.count - 1'b1;
                end
                else
                begin
                    upd_err = ERR_DEC_AT_ZERO;
                end
            end
            OP_QUERY:
            begin
                upd_entry = rd_entry;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        credit_next    = credit_reg;
        range_next     = range_reg;
        frac_next      = frac_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_frac_next  = out_frac_reg;
        out_err_next   = out_err_reg;
        tbl_wr_en      = 1'b0;
        div_start      = 1'b0;
        s_axis_tready  = 1'b0;

        // drop the result once the sink has taken it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next     = in_op;
                    idx_next    = in_idx;
                    credit_next = in_credit;
                    range_next  = in_range;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                tbl_wr_en = range_reg;
                if (!range_reg || upd_entry.maximum == '0)
                begin
                    frac_next  = '0;
                    err_next   = ERR_MAX_ZERO;
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    err_next   = upd_err;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    frac_next  = div_quot;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free, then hand the result over
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_frac_next  = frac_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        credit_reg   <= credit_next;
        range_reg    <= range_next;
        frac_reg     <= frac_next;
        err_reg      <= err_next;
        out_frac_reg <= out_frac_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_err_reg, out_frac_reg});

endmodule
